FILE: design/byte_ring_fifo_overwrite_top_defines.svh
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Shared property forms for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_OVERWRITE_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_OVERWRITE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define BRFO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("byte ring FIFO check failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define BRFO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("byte ring FIFO check failed");

`endif

FILE: design/brfo_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Field widths, operation, status and register codes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package brfo_pkg;

    localparam int FUNC_W     = 2;
    localparam int DATA_W     = 8;
    localparam int PIDX_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 8;
    localparam int RING_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int DEPTH_DEFAULT = 256;

    localparam logic [RING_W-1:0] RING_SIZE_RESET = 9'd256;
    localparam logic [RING_W-1:0] RING_SIZE_MIN   = 9'd2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_GET   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PUT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GET_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PEEK_RANGE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 2'd1;

endpackage

`default_nettype wire

FILE: design/brfo_ram.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO slot memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brfo_ram #(
    parameter int DEPTH  = brfo_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [ADDR_W-1:0]           i_waddr,
    input  wire logic [brfo_pkg::DATA_W-1:0] i_wdata,
    input  wire logic                        i_re,
    input  wire logic [ADDR_W-1:0]           i_raddr,
    output logic      [brfo_pkg::DATA_W-1:0] o_rdata
);

    logic [brfo_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [brfo_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/brfo_mod.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO pointer reduction unit
// Restoring remainder of a pointer by the ring size, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module brfo_mod #(
    parameter int PTR_W   = 8,
    parameter int ARITH_W = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [PTR_W-1:0]   i_value,
    input  wire logic [ARITH_W-1:0] i_divisor,
    output logic      [PTR_W-1:0]   o_rem,
    output logic                    o_done
);

    localparam int CNT_W = $clog2(PTR_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   r_val;
    logic [ARITH_W-1:0] r_rem;
    logic [ARITH_W:0]   trial;
    logic [ARITH_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_val[PTR_W-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = ARITH_W'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = trial[ARITH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PTR_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= r_val << 1;
            r_rem <= n_rem;
        end
    end

    assign o_rem  = r_rem[PTR_W-1:0];
    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: design/byte_ring_fifo_overwrite_top.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO with overwrite
// Circular byte store with one reserved slot: put, get, peek and clear.
//
//  Channel   Handshake                 Payload
//  command   start / busy              i_func, i_data_in, i_peek_index
//  result    o_result_valid (strobe)   o_status, o_data_out, o_dropped_oldest,
//                                      o_fill_count, o_fifo_empty, o_is_full
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A command is executed in the cycle it is accepted and its result strobes
// in the next cycle, when the slot memory's registered read data is available.
// With both pointers inside the ring, busy stays low and one command per
// cycle is taken. If a ring size change left a pointer outside the ring, the
// command first waits, with busy high, for the bit-serial pointer reduction.
// Reset clears the pointers and the configuration registers; the slot memory
// is not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_overwrite_top #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [brfo_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [brfo_pkg::DATA_W-1:0]     i_data_in,
    input  wire logic [brfo_pkg::PIDX_W-1:0]     i_peek_index,
    output logic                                 o_result_valid,
    output logic      [brfo_pkg::STATUS_W-1:0]   o_status,
    output logic      [brfo_pkg::DATA_W-1:0]     o_data_out,
    output logic                                 o_dropped_oldest,
    output logic      [brfo_pkg::FILL_W-1:0]     o_fill_count,
    output logic                                 o_fifo_empty,
    output logic                                 o_is_full,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [brfo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [brfo_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ARITH_W = ((PTR_W > brfo_pkg::RING_W) ? PTR_W : brfo_pkg::RING_W) + 1;

    localparam logic [ARITH_W-1:0] DEPTH_A = ARITH_W'(DEPTH);
    localparam logic [ARITH_W-1:0] RST_EFF =
        (ARITH_W'(brfo_pkg::RING_SIZE_RESET) > DEPTH_A) ? DEPTH_A
                                                        : ARITH_W'(brfo_pkg::RING_SIZE_RESET);

    localparam logic [1:0] FSM_IDLE   = 2'd0;
    localparam logic [1:0] FSM_REDUCE = 2'd1;
    localparam logic [1:0] FSM_EXEC   = 2'd2;

    logic [1:0]               r_state;
    logic [ARITH_W-1:0]       r_eff_size;
    logic                     r_overwrite;
    logic [PTR_W-1:0]         r_wp;
    logic [PTR_W-1:0]         r_rp;

    logic [brfo_pkg::FUNC_W-1:0] r_func;
    logic [brfo_pkg::DATA_W-1:0] r_data;
    logic [brfo_pkg::PIDX_W-1:0] r_pidx;

    logic                          r_res_valid;
    logic [brfo_pkg::STATUS_W-1:0] r_status;
    logic                          r_dropped;
    logic [brfo_pkg::FILL_W-1:0]   r_fill;
    logic                          r_empty;
    logic                          r_full;
    logic                          r_use_ram;

    logic                          cfg_we;
    logic [ARITH_W-1:0]            cfg_ring;
    logic                          accept;
    logic                          need_reduce;
    logic                          do_exec;
    logic                          mod_start;
    logic                          wp_done;
    logic                          rp_done;
    logic [PTR_W-1:0]              wp_rem;
    logic [PTR_W-1:0]              rp_rem;

    logic [brfo_pkg::FUNC_W-1:0]   cur_func;
    logic [brfo_pkg::DATA_W-1:0]   cur_data;
    logic [brfo_pkg::PIDX_W-1:0]   cur_pidx;

    logic [ARITH_W-1:0]            wp_x;
    logic [ARITH_W-1:0]            rp_x;
    logic [ARITH_W-1:0]            wp_inc;
    logic [ARITH_W-1:0]            rp_inc;
    logic [ARITH_W-1:0]            wp_plus;
    logic [ARITH_W-1:0]            rp_plus;
    logic [ARITH_W-1:0]            fill_pre;
    logic [ARITH_W-1:0]            fill_post;
    logic [ARITH_W-1:0]            peek_sum;
    logic [ARITH_W-1:0]            peek_addr;
    logic                          ring_full;

    logic [PTR_W-1:0]              n_wp;
    logic [PTR_W-1:0]              n_rp;
    logic [brfo_pkg::STATUS_W-1:0] n_status;
    logic                          n_dropped;
    logic                          n_use_ram;
    logic                          ram_we;
    logic                          ram_re;
    logic [PTR_W-1:0]              ram_raddr;
    logic [brfo_pkg::DATA_W-1:0]   ram_rdata;

    // ------------------------------------------------------------------
    // Configuration: the ring size is stored already clamped to [2, DEPTH].
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_ring    = ARITH_W'(i_cfg_data[brfo_pkg::RING_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_size  <= RST_EFF;
            r_overwrite <= 1'b0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                brfo_pkg::CFG_RING_SIZE: begin
                    if (cfg_ring < ARITH_W'(brfo_pkg::RING_SIZE_MIN)) begin
                        r_eff_size <= ARITH_W'(brfo_pkg::RING_SIZE_MIN);
                    end else if (cfg_ring > DEPTH_A) begin
                        r_eff_size <= DEPTH_A;
                    end else begin
                        r_eff_size <= cfg_ring;
                    end
                end
                brfo_pkg::CFG_OVERWRITE: begin
                    r_overwrite <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Command acceptance and sequencing.
    // ------------------------------------------------------------------
    assign busy        = (r_state != FSM_IDLE);
    assign accept      = start && !busy;
    assign wp_x        = ARITH_W'(r_wp);
    assign rp_x        = ARITH_W'(r_rp);
    assign need_reduce = (wp_x >= r_eff_size) || (rp_x >= r_eff_size);
    assign mod_start   = accept && need_reduce;
    assign do_exec     = (accept && !need_reduce) || (r_state == FSM_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            case (r_state)
                FSM_IDLE: begin
                    if (mod_start) begin
                        r_state <= FSM_REDUCE;
                    end
                end
                FSM_REDUCE: begin
                    if (wp_done) begin
                        r_state <= FSM_EXEC;
                    end
                end
                FSM_EXEC: begin
                    r_state <= FSM_IDLE;
                end
                default: begin
                    r_state <= FSM_IDLE;
                end
            endcase
        end
    end

    // A command that has to wait for pointer reduction is held here.
    always_ff @(posedge i_clk) begin
        if (mod_start) begin
            r_func <= i_func;
            r_data <= i_data_in;
            r_pidx <= i_peek_index;
        end
    end

    brfo_mod #(
        .PTR_W   (PTR_W),
        .ARITH_W (ARITH_W)
    ) u_wp_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_value   (r_wp),
        .i_divisor (r_eff_size),
        .o_rem     (wp_rem),
        .o_done    (wp_done)
    );

    brfo_mod #(
        .PTR_W   (PTR_W),
        .ARITH_W (ARITH_W)
    ) u_rp_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_value   (r_rp),
        .i_divisor (r_eff_size),
        .o_rem     (rp_rem),
        .o_done    (rp_done)
    );

    // ------------------------------------------------------------------
    // Operation datapath, with both pointers inside the ring.
    // ------------------------------------------------------------------
    assign cur_func = (r_state == FSM_EXEC) ? r_func : i_func;
    assign cur_data = (r_state == FSM_EXEC) ? r_data : i_data_in;
    assign cur_pidx = (r_state == FSM_EXEC) ? r_pidx : i_peek_index;

    assign wp_plus   = wp_x + ARITH_W'(1);
    assign rp_plus   = rp_x + ARITH_W'(1);
    assign wp_inc    = (wp_plus == r_eff_size) ? '0 : wp_plus;
    assign rp_inc    = (rp_plus == r_eff_size) ? '0 : rp_plus;
    assign fill_pre  = (wp_x >= rp_x) ? (wp_x - rp_x) : (r_eff_size - rp_x + wp_x);
    assign ring_full = (wp_inc == rp_x);

    // A peek that passes the range check lands below twice the ring size.
    assign peek_sum  = rp_x + ARITH_W'(cur_pidx);
    assign peek_addr = (peek_sum >= r_eff_size) ? (peek_sum - r_eff_size) : peek_sum;

    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_status  = brfo_pkg::ST_DONE;
        n_dropped = 1'b0;
        n_use_ram = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_rp;
        fill_post = fill_pre;
        case (cur_func)
            brfo_pkg::FN_PUT: begin
                if (ring_full && !r_overwrite) begin
                    n_status = brfo_pkg::ST_PUT_FULL;
                end else begin
                    ram_we = do_exec;
                    n_wp   = wp_inc[PTR_W-1:0];
                    if (ring_full) begin
                        n_rp      = rp_inc[PTR_W-1:0];
                        n_dropped = 1'b1;
                    end else begin
                        fill_post = fill_pre + ARITH_W'(1);
                    end
                end
            end
            brfo_pkg::FN_GET: begin
                if (wp_x == rp_x) begin
                    n_status = brfo_pkg::ST_GET_EMPTY;
                end else begin
                    ram_re    = do_exec;
                    n_use_ram = 1'b1;
                    n_rp      = rp_inc[PTR_W-1:0];
                    fill_post = fill_pre - ARITH_W'(1);
                end
            end
            brfo_pkg::FN_PEEK: begin
                if (ARITH_W'(cur_pidx) >= fill_pre) begin
                    n_status = brfo_pkg::ST_PEEK_RANGE;
                end else begin
                    ram_re    = do_exec;
                    n_use_ram = 1'b1;
                    ram_raddr = peek_addr[PTR_W-1:0];
                end
            end
            brfo_pkg::FN_CLEAR: begin
                n_wp      = '0;
                n_rp      = '0;
                fill_post = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else if (wp_done && rp_done) begin
            r_wp <= wp_rem;
            r_rp <= rp_rem;
        end else if (do_exec) begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    brfo_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (cur_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= do_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_exec) begin
            r_status  <= n_status;
            r_dropped <= n_dropped;
            r_use_ram <= n_use_ram;
            r_fill    <= fill_post[brfo_pkg::FILL_W-1:0];
            r_empty   <= (fill_post == '0);
            r_full    <= (fill_post == (r_eff_size - ARITH_W'(1)));
        end
    end

    assign o_result_valid   = r_res_valid;
    assign o_status         = r_status;
    assign o_data_out       = r_use_ram ? ram_rdata : '0;
    assign o_dropped_oldest = r_dropped;
    assign o_fill_count     = r_fill;
    assign o_fifo_empty     = r_empty;
    assign o_is_full        = r_full;

endmodule

`default_nettype wire

FILE: design/brfo_checker.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO port checker
// Watches the top-level ports and checks result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_ring_fifo_overwrite_top_defines.svh"

module brfo_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_result_valid,
    input wire logic [brfo_pkg::STATUS_W-1:0] o_status,
    input wire logic [brfo_pkg::DATA_W-1:0]   o_data_out,
    input wire logic                          o_dropped_oldest,
    input wire logic                          o_fifo_empty,
    input wire logic                          o_is_full
);

    logic drop_seen;
    logic fail_seen;
    logic accept_seen;

    assign drop_seen   = o_result_valid && o_dropped_oldest;
    assign fail_seen   = o_result_valid && (o_status != brfo_pkg::ST_DONE);
    assign accept_seen = start && !busy;

    // Dropping the oldest byte only happens on a full ring, which stays full.
    `BRFO_ASSERT_IMP(a_drop_keeps_full, drop_seen, o_status == brfo_pkg::ST_DONE && o_is_full)

    // Failed transactions never return a data byte.
    `BRFO_ASSERT_IMP(a_fail_no_data, fail_seen, o_data_out == '0)

    // Capacity is at least one byte, so the ring is never empty and full at once.
    `BRFO_ASSERT_IMP(a_empty_full_excl, o_result_valid, !(o_fifo_empty && o_is_full))

    // An accepted command either strobes its result next cycle or holds busy.
    `BRFO_ASSERT_NEXT(a_accept_progress, accept_seen, o_result_valid || busy)

    // A result strobe always follows an accepted command or a busy cycle.
    `BRFO_ASSERT_IMP(a_no_spurious_result, o_result_valid, $past(start) || $past(busy))

endmodule

bind byte_ring_fifo_overwrite_top brfo_checker u_brfo_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO testbench
// Drives put, get, peek and clear commands through the start/busy port and
// checks every result strobe against a ring buffer model kept here. Covers
// the ring size extremes, overwrite on and off, and ring size changes made
// without a clear. Random traffic with sender gaps follows a short directed
// part.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = brfo_pkg::DEPTH_DEFAULT;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 1000;

    // Register indexes that map to nothing; writes to them must be ignored.
    localparam logic [brfo_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
    localparam logic [brfo_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_3 = 2'd3;

    typedef struct packed {
        logic [brfo_pkg::STATUS_W-1:0] status;
        logic [brfo_pkg::DATA_W-1:0]   data;
        logic                          dropped;
        logic [brfo_pkg::FILL_W-1:0]   fill;
        logic                          empty;
        logic                          full;
    } t_op_outcome;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [brfo_pkg::FUNC_W-1:0]     i_func = brfo_pkg::FN_PUT;
    logic [brfo_pkg::DATA_W-1:0]     i_data_in = '0;
    logic [brfo_pkg::PIDX_W-1:0]     i_peek_index = '0;
    logic                            o_result_valid;
    logic [brfo_pkg::STATUS_W-1:0]   o_status;
    logic [brfo_pkg::DATA_W-1:0]     o_data_out;
    logic                            o_dropped_oldest;
    logic [brfo_pkg::FILL_W-1:0]     o_fill_count;
    logic                            o_fifo_empty;
    logic                            o_is_full;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [brfo_pkg::CFG_IDX_W-1:0]  i_cfg_index = brfo_pkg::CFG_RING_SIZE;
    logic [brfo_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Ring buffer state as the block should hold it.
    logic [brfo_pkg::RING_W-1:0] ring_size_reg = brfo_pkg::RING_SIZE_RESET;
    logic                        overwrite_reg = 1'b0;
    int unsigned                 wr_ptr = 0;
    int unsigned                 rd_ptr = 0;
    logic [brfo_pkg::DATA_W-1:0] slot_copy [DEPTH];
    bit                          slot_written [DEPTH];

    t_op_outcome op_outcomes[$];
    t_op_outcome got_r;
    t_op_outcome want_r;
    int          n_errors = 0;
    int          n_cycles = 0;
    bit          sender_idles = 1'b1;

    byte_ring_fifo_overwrite_top #(.DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_data_in       (i_data_in),
        .i_peek_index    (i_peek_index),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_data_out      (o_data_out),
        .o_dropped_oldest(o_dropped_oldest),
        .o_fill_count    (o_fill_count),
        .o_fifo_empty    (o_fifo_empty),
        .o_is_full       (o_is_full),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned ring_eff();
        int unsigned s;
        s = 32'(ring_size_reg);
        if (s < 32'(brfo_pkg::RING_SIZE_MIN)) s = 32'(brfo_pkg::RING_SIZE_MIN);
        if (s > DEPTH) s = DEPTH;
        return s;
    endfunction

    function automatic int unsigned ring_step(int unsigned p, int unsigned s);
        return (p + 1 >= s) ? p + 1 - s : p + 1;
    endfunction

    function automatic int unsigned held_count(int unsigned w, int unsigned r,
                                               int unsigned s);
        return (w >= r) ? w - r : s - r + w;
    endfunction

    function automatic int unsigned current_fill();
        int unsigned s;
        s = ring_eff();
        return held_count(wr_ptr % s, rd_ptr % s, s);
    endfunction

    // Applies one command to the ring state and returns what the block reports.
    function automatic t_op_outcome ring_op(logic [brfo_pkg::FUNC_W-1:0] fn,
                                            logic [brfo_pkg::DATA_W-1:0] din,
                                            logic [brfo_pkg::PIDX_W-1:0] pidx);
        t_op_outcome r;
        int unsigned s;
        int unsigned nxt;
        int unsigned addr;
        int unsigned fill;
        r = '0;
        s = ring_eff();
        // Pointers left outside a shrunken ring are folded back first.
        if (wr_ptr >= s) wr_ptr = wr_ptr % s;
        if (rd_ptr >= s) rd_ptr = rd_ptr % s;
        case (fn)
            brfo_pkg::FN_PUT: begin
                nxt = ring_step(wr_ptr, s);
                if (nxt == rd_ptr && !overwrite_reg) begin
                    r.status = brfo_pkg::ST_PUT_FULL;
                end else begin
                    if (nxt == rd_ptr) begin
                        rd_ptr = ring_step(rd_ptr, s);
                        r.dropped = 1'b1;
                    end
                    slot_copy[IDX_W'(wr_ptr)] = din;
                    slot_written[IDX_W'(wr_ptr)] = 1'b1;
                    wr_ptr = nxt;
                end
            end
            brfo_pkg::FN_GET: begin
                if (wr_ptr == rd_ptr) begin
                    r.status = brfo_pkg::ST_GET_EMPTY;
                end else begin
                    r.data = slot_copy[IDX_W'(rd_ptr)];
                    rd_ptr = ring_step(rd_ptr, s);
                end
            end
            brfo_pkg::FN_PEEK: begin
                if (32'(pidx) >= held_count(wr_ptr, rd_ptr, s)) begin
                    r.status = brfo_pkg::ST_PEEK_RANGE;
                end else begin
                    addr = rd_ptr + 32'(pidx);
                    if (addr >= s) addr -= s;
                    r.data = slot_copy[IDX_W'(addr)];
                end
            end
            default: begin
                wr_ptr = 0;
                rd_ptr = 0;
            end
        endcase
        fill = held_count(wr_ptr, rd_ptr, s);
        r.fill = fill[brfo_pkg::FILL_W-1:0];
        r.empty = (fill == 0);
        r.full = (fill == s - 1);
        return r;
    endfunction

    task automatic send_cmd(input logic [brfo_pkg::FUNC_W-1:0] fn,
                            input logic [brfo_pkg::DATA_W-1:0] din,
                            input logic [brfo_pkg::PIDX_W-1:0] pidx);
        int unsigned s;
        int unsigned rp;
        int unsigned addr;
        s = ring_eff();
        rp = rd_ptr % s;
        addr = rp + 32'(pidx);
        if (addr >= s) addr -= s;
        // A read that would land on a slot never written since reset becomes a put.
        if (fn == brfo_pkg::FN_GET && current_fill() != 0 && !slot_written[IDX_W'(rp)])
            fn = brfo_pkg::FN_PUT;
        if (fn == brfo_pkg::FN_PEEK && 32'(pidx) < current_fill() &&
            !slot_written[IDX_W'(addr)])
            fn = brfo_pkg::FN_PUT;
        @(negedge i_clk);
        start <= 1'b1;
        i_func <= fn;
        i_data_in <= din;
        i_peek_index <= pidx;
        do @(posedge i_clk); while (busy);
        op_outcomes.push_back(ring_op(fn, din, pidx));
    endtask

    task automatic maybe_idle();
        if (sender_idles && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (op_outcomes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [brfo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brfo_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == brfo_pkg::CFG_RING_SIZE) ring_size_reg = value;
        else if (idx == brfo_pkg::CFG_OVERWRITE) overwrite_reg = value[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_op(input int put_pct);
        int                          r;
        int unsigned                 fill;
        logic [brfo_pkg::PIDX_W-1:0] pidx;
        r = $urandom_range(0, 99);
        fill = current_fill();
        if ($urandom_range(0, 3) != 0)
            pidx = 8'($urandom_range(0, (fill + 1 > 255) ? 255 : fill + 1));
        else
            pidx = 8'($urandom_range(0, 255));
        if (r < 3)
            send_cmd(brfo_pkg::FN_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else if (r < 3 + put_pct)
            send_cmd(brfo_pkg::FN_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 2) == 0)
            send_cmd(brfo_pkg::FN_PEEK, 8'($urandom_range(0, 255)), pidx);
        else
            send_cmd(brfo_pkg::FN_GET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        maybe_idle();
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            got_r = {o_status, o_data_out, o_dropped_oldest, o_fill_count,
                     o_fifo_empty, o_is_full};
            if (op_outcomes.size() == 0) begin
                $display("%0t ns: result with none expected, expected nothing, actual %h",
                         $time, got_r);
                n_errors++;
            end else begin
                want_r = op_outcomes.pop_front();
                check_field("status", 8'(want_r.status), 8'(got_r.status));
                check_field("data_out", want_r.data, got_r.data);
                check_field("dropped_oldest", 8'(want_r.dropped), 8'(got_r.dropped));
                check_field("fill_count", want_r.fill, got_r.fill);
                check_field("fifo_empty", 8'(want_r.empty), 8'(got_r.empty));
                check_field("is_full", 8'(want_r.full), 8'(got_r.full));
            end
        end
    end

    task automatic test_directed();
        wait_drained();
        send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'hFF, 8'hFF);
        send_cmd(brfo_pkg::FN_PUT, 8'hA5, 8'h00);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'h02);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'h03);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'hFF);
        send_cmd(brfo_pkg::FN_GET, 8'hFF, 8'hFF);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h5A, 8'h01);
        send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
        wait_drained();
        // Smallest ring: a single byte fills it.
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd2);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h5A, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h3C, 8'h00);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'h00);
        wait_drained();
        cfg_write(brfo_pkg::CFG_OVERWRITE, 9'd1);
        send_cmd(brfo_pkg::FN_PUT, 8'hC3, 8'h00);
        send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
        wait_drained();
        cfg_write(brfo_pkg::CFG_OVERWRITE, 9'd0);
    endtask

    task automatic test_fill_and_wrap();
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd256);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h00, 8'h00);
        repeat (255) begin
            send_cmd(brfo_pkg::FN_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            maybe_idle();
        end
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'd254);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'd255);
        send_cmd(brfo_pkg::FN_PUT, 8'h77, 8'h00);
        wait_drained();
        cfg_write(brfo_pkg::CFG_OVERWRITE, 9'd1);
        // Each put now drops the oldest byte and the write pointer wraps.
        repeat (20) begin
            send_cmd(brfo_pkg::FN_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            maybe_idle();
        end
        repeat (257) begin
            send_cmd(brfo_pkg::FN_GET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            maybe_idle();
        end
    endtask

    task automatic test_config_extremes();
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd0);
        cfg_write(brfo_pkg::CFG_OVERWRITE, 9'h1FE);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h11, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h22, 8'h00);
        send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd1);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h33, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h44, 8'h00);
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd511);
        cfg_write(brfo_pkg::CFG_OVERWRITE, 9'h001);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h00, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h55, 8'h00);
        send_cmd(brfo_pkg::FN_PUT, 8'h66, 8'h00);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'h01);
        send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd257);
        cfg_write(CFG_UNMAPPED_2, 9'($urandom_range(0, 511)));
        cfg_write(CFG_UNMAPPED_3, 9'($urandom_range(0, 511)));
        send_cmd(brfo_pkg::FN_PUT, 8'h88, 8'h00);
        send_cmd(brfo_pkg::FN_PEEK, 8'h00, 8'h01);
        send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd3);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h00, 8'h00);
        repeat (3) send_cmd(brfo_pkg::FN_PUT, 8'($urandom_range(0, 255)), 8'h00);
        repeat (3) send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
    endtask

    task automatic test_resize_without_clear();
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd256);
        cfg_write(brfo_pkg::CFG_OVERWRITE, 9'd0);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h00, 8'h00);
        repeat (40) send_cmd(brfo_pkg::FN_PUT, 8'($urandom_range(0, 255)), 8'h00);
        repeat (10) send_cmd(brfo_pkg::FN_GET, 8'h00, 8'h00);
        wait_drained();
        // The write pointer now sits beyond the new ring and must be folded back.
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd16);
        repeat (24) random_op(50);
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd5);
        repeat (15) random_op(50);
        wait_drained();
        cfg_write(brfo_pkg::CFG_RING_SIZE, 9'd256);
        repeat (10) random_op(50);
        send_cmd(brfo_pkg::FN_CLEAR, 8'h00, 8'h00);
    endtask

    task automatic test_random_traffic();
        logic [brfo_pkg::CFG_DATA_W-1:0] sz;
        logic [7:0]                      junk;
        logic                            ovw;
        int                              put_pct;
        int                              n;
        for (int ph = 0; ph < 16; ph++) begin
            wait_drained();
            case ($urandom_range(0, 7))
                0: sz = 9'($urandom_range(0, 1));
                1: sz = 9'd2;
                2: sz = 9'd3;
                3: sz = 9'($urandom_range(4, 16));
                4: sz = 9'($urandom_range(17, 255));
                5: sz = 9'd256;
                6: sz = 9'($urandom_range(257, 511));
                default: sz = 9'($urandom_range(4, 40));
            endcase
            junk = 8'($urandom_range(0, 255));
            ovw = 1'($urandom_range(0, 1));
            cfg_write(brfo_pkg::CFG_RING_SIZE, sz);
            cfg_write(brfo_pkg::CFG_OVERWRITE, {junk, ovw});
            if ($urandom_range(0, 4) != 0)
                send_cmd(brfo_pkg::FN_CLEAR, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            put_pct = $urandom_range(20, 80);
            n = $urandom_range(50, 110);
            // The closing phase runs back to back with no sender gaps.
            if (ph == 15) begin
                sender_idles = 1'b0;
                n = 150;
            end
            repeat (n) begin
                random_op(put_pct);
                if (sender_idles && $urandom_range(0, 99) == 0) wait_drained();
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_and_wrap();
        test_config_extremes();
        test_resize_without_clear();
        test_random_traffic();
        @(negedge i_clk);
        start <= 1'b0;
        repeat (DRAIN_LIMIT) if (op_outcomes.size() != 0) @(posedge i_clk);
        if (op_outcomes.size() != 0) begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, op_outcomes.size());
            n_errors++;
        end
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
